// ===== rtl/iplk_pkg.sv =====
// Shared types, constants and the op-class latency table for the pipeline interlock block.
// No dependencies; every other file of the block takes its names from here.
package iplk_pkg;

	localparam int REG_W = 5;
	localparam int SEQ_W = 16;
	localparam int CLS_W = 5;
	localparam int LAT_W = 5;
	localparam int NSRC_W = 2;
	localparam int BUSY_W = 3;
	localparam int BUSY_SAT = 7;
	localparam int WAIT_SLOTS = 2;
	localparam int WCNT_W = 2;
	localparam int WCNT_SAT = 3;
	localparam int CLASS_COUNT = 32;
	localparam int REGISTER_COUNT_DEF = 32;
	localparam int LATENCY_MAX_DEF = 16;

	// One instruction as it is offered to fetch
	typedef struct packed {
		logic              trace_end;
		logic [NSRC_W-1:0] source_count;
		logic [REG_W-1:0]  source_a;
		logic [REG_W-1:0]  source_b;
		logic              dest_present;
		logic [REG_W-1:0]  dest_reg;
		logic              is_branch;
		logic [CLS_W-1:0]  op_class;
	} in_item_t;

	// Contents of one modeled stage latch
	typedef struct packed {
		logic              valid;
		logic              is_end;
		logic [SEQ_W-1:0]  seq;
		logic [NSRC_W-1:0] nsrc;
		logic [REG_W-1:0]  src_a;
		logic [REG_W-1:0]  src_b;
		logic              has_dest;
		logic [REG_W-1:0]  dest;
		logic              branch;
		logic [CLS_W-1:0]  op_class;
	} stage_t;

	// One result item
	typedef struct packed {
		logic             fetch_accept;
		logic             retire_valid;
		logic [SEQ_W-1:0] retire_seq;
		logic             data_stall;
		logic             control_stall;
		logic             exec_stall;
		logic             sim_done;
	} result_t;

	// Scoreboard lookup: writeback release plus the two decode sources
	typedef struct packed {
		logic             dec_en;
		logic [REG_W-1:0] dec_reg;
		logic [REG_W-1:0] src_a;
		logic [REG_W-1:0] src_b;
	} sb_rd_t;

	// Scoreboard claim from decode
	typedef struct packed {
		logic             inc_en;
		logic [REG_W-1:0] inc_reg;
	} sb_wr_t;

	typedef struct packed {
		logic busy_a;
		logic busy_b;
	} sb_busy_t;

	function automatic logic [LAT_W-1:0] class_latency(input logic [CLS_W-1:0] cls);
		logic [LAT_W-1:0] lat;
		case (cls)
			5'd8:  lat = 5'd2;
			5'd9:  lat = 5'd4;
			5'd10: lat = 5'd2;
			5'd12: lat = 5'd2;
			5'd14: lat = 5'd2;
			5'd15: lat = 5'd2;
			5'd17: lat = 5'd4;
			5'd18: lat = 5'd2;
			5'd19: lat = 5'd4;
			5'd20: lat = 5'd16;
			5'd21: lat = 5'd2;
			5'd22: lat = 5'd2;
			default: lat = 5'd1;
		endcase
		if (int'(cls) >= CLASS_COUNT)
			lat = 5'd1;
		return lat;
	endfunction

endpackage

// ===== rtl/inorder_pipeline_interlock_core.sv =====
// A result passes through the input register (stage 1) and then the output register (stage 2).
// Throughput: one input transfer per cycle while the output is not stalled; a new item is taken while a result waits.
// Each item is one modeled clock tick, evaluated in a single pass from the input register.
// Reset (arst_n low, asynchronous): all stage latches empty, busy counts, flags and counters zero.
// Depends on iplk_pkg; instantiates iplk_core.
module inorder_pipeline_interlock_core #(
	parameter int REGISTER_COUNT = iplk_pkg::REGISTER_COUNT_DEF,
	parameter int LATENCY_MAX    = iplk_pkg::LATENCY_MAX_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         trace_end,
	input  logic [iplk_pkg::NSRC_W-1:0]  source_count,
	input  logic [iplk_pkg::REG_W-1:0]   source_a,
	input  logic [iplk_pkg::REG_W-1:0]   source_b,
	input  logic                         dest_present,
	input  logic [iplk_pkg::REG_W-1:0]   dest_reg,
	input  logic                         is_branch,
	input  logic [iplk_pkg::CLS_W-1:0]   op_class,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         fetch_accept,
	output logic                         retire_valid,
	output logic [iplk_pkg::SEQ_W-1:0]   retire_seq,
	output logic                         data_stall,
	output logic                         control_stall,
	output logic                         exec_stall,
	output logic                         sim_done
);

	// Stage 1 holds the offered instruction; stage 2 holds the tick's result.
	iplk_pkg::in_item_t item_s1;
	logic               valid_s1;
	iplk_pkg::result_t  res;
	iplk_pkg::result_t  res_s2;
	logic               valid_s2;
	logic               advance;

	// Advance a tick whenever the result register is free or being drained this cycle.
	assign advance  = valid_s1 & (~valid_s2 | out_ready);
	// Take a new transfer whenever stage 1 is empty or empties in the same cycle.
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	// Payload: load on transfer, hold otherwise.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.trace_end    <= trace_end;
			item_s1.source_count <= source_count;
			item_s1.source_a     <= source_a;
			item_s1.source_b     <= source_b;
			item_s1.dest_present <= dest_present;
			item_s1.dest_reg     <= dest_reg;
			item_s1.is_branch    <= is_branch;
			item_s1.op_class     <= op_class;
		end
	end

	// All stage state lives in the core and updates only on advance.
	iplk_core #(
		.REGISTER_COUNT(REGISTER_COUNT),
		.LATENCY_MAX   (LATENCY_MAX)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (advance),
		.item  (item_s1),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (out_ready)
			valid_s2 <= 1'b0;
	end

	// Hold the result until its transfer completes.
	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res;
	end

	assign out_valid     = valid_s2;
	assign fetch_accept  = res_s2.fetch_accept;
	assign retire_valid  = res_s2.retire_valid;
	assign retire_seq    = res_s2.retire_seq;
	assign data_stall    = res_s2.data_stall;
	assign control_stall = res_s2.control_stall;
	assign exec_stall    = res_s2.exec_stall;
	assign sim_done      = res_s2.sim_done;

endmodule

// ===== rtl/iplk_scoreboard.sv =====
// Per-register busy counters of the interlock scoreboard.
// Depends on iplk_pkg for the lookup and claim structs.
module iplk_scoreboard #(
	parameter int REGISTER_COUNT = iplk_pkg::REGISTER_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  iplk_pkg::sb_rd_t   rd,
	input  iplk_pkg::sb_wr_t   wr,
	output iplk_pkg::sb_busy_t busy
);

	localparam int REG_SPAN = 2 ** iplk_pkg::REG_W;
	localparam int CELLS = (REGISTER_COUNT < REG_SPAN) ? REGISTER_COUNT : REG_SPAN;

	logic [iplk_pkg::BUSY_W-1:0] cnt_q [CELLS];
	logic [CELLS-1:0]            hit_a;
	logic [CELLS-1:0]            hit_b;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		logic                        dec;
		logic                        inc;
		logic [iplk_pkg::BUSY_W-1:0] mid;

		// release first, then look up and claim on the released count
		assign dec = rd.dec_en && (rd.dec_reg == iplk_pkg::REG_W'(i)) && (cnt_q[i] != '0);
		assign mid = cnt_q[i] - iplk_pkg::BUSY_W'(dec);
		assign hit_a[i] = (mid != '0) && (rd.src_a == iplk_pkg::REG_W'(i));
		assign hit_b[i] = (mid != '0) && (rd.src_b == iplk_pkg::REG_W'(i));
		assign inc = wr.inc_en && (wr.inc_reg == iplk_pkg::REG_W'(i))
			&& (mid != iplk_pkg::BUSY_W'(iplk_pkg::BUSY_SAT));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cnt_q[i] <= '0;
			else
				cnt_q[i] <= mid + iplk_pkg::BUSY_W'(inc);
		end
	end

	assign busy.busy_a = |hit_a;
	assign busy.busy_b = |hit_b;

endmodule

// ===== rtl/iplk_core.sv =====
// Modeled stage latches, execute countdown, stall flags and wait slots; one tick per strobe until done.
// Depends on iplk_pkg and instantiates iplk_scoreboard.
module iplk_core #(
	parameter int REGISTER_COUNT = iplk_pkg::REGISTER_COUNT_DEF,
	parameter int LATENCY_MAX    = iplk_pkg::LATENCY_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick,
	input  iplk_pkg::in_item_t item,
	output iplk_pkg::result_t res
);

	localparam int CD_W = $clog2(LATENCY_MAX + 1);
	localparam int SL = iplk_pkg::WAIT_SLOTS;

	iplk_pkg::stage_t fetch_q, decode_q, exec_q, mem_q;
	iplk_pkg::stage_t fetch_n, decode_n, exec_n, mem_n;
	logic [CD_W-1:0] cnt_q, cnt_n;
	logic dstall_q, dstall_n, cstall_q, cstall_n, xstall_q, xstall_n;
	logic [SL-1:0] wv_q, wv_n;
	logic [SL-1:0][iplk_pkg::REG_W-1:0] wr_q, wr_n;
	logic [iplk_pkg::WCNT_W-1:0] wcnt_q, wcnt_n;
	logic [iplk_pkg::SEQ_W-1:0] seq_q, seq_n;
	logic done_q, done_n;

	logic commit;
	logic retired;
	logic ex_go;
	logic hit_a, hit_b;
	logic accept;
	logic [iplk_pkg::LAT_W-1:0] lat_raw, lat_dec;

	iplk_pkg::sb_rd_t   sb_rd;
	iplk_pkg::sb_wr_t   sb_wr;
	iplk_pkg::sb_busy_t sb_busy;

	assign commit = tick & ~done_q;

	assign sb_rd.dec_en  = commit & mem_q.valid & ~mem_q.is_end & mem_q.has_dest;
	assign sb_rd.dec_reg = mem_q.dest;
	assign sb_rd.src_a   = fetch_q.src_a;
	assign sb_rd.src_b   = fetch_q.src_b;

	iplk_scoreboard #(
		.REGISTER_COUNT(REGISTER_COUNT)
	) u_sb (
		.clk   (clk),
		.arst_n(arst_n),
		.rd    (sb_rd),
		.wr    (sb_wr),
		.busy  (sb_busy)
	);

	// end marker bypasses the class table; clamp the table to the configured ceiling
	assign lat_raw = decode_q.is_end ? iplk_pkg::LAT_W'(1)
		: iplk_pkg::class_latency(decode_q.op_class);
	assign lat_dec = (int'(lat_raw) > LATENCY_MAX) ? iplk_pkg::LAT_W'(LATENCY_MAX) : lat_raw;

	always_comb begin
		// writeback
		retired  = mem_q.valid & ~mem_q.is_end;
		done_n   = done_q | (mem_q.valid & mem_q.is_end);
		cstall_n = cstall_q & ~(retired & mem_q.branch);
		dstall_n = dstall_q;
		wv_n     = wv_q;
		wr_n     = wr_q;
		wcnt_n   = wcnt_q;
		for (int i = 0; i < SL; i++) begin
			if (retired && mem_q.has_dest && wv_q[i] && (wr_q[i] == mem_q.dest)) begin
				if (wcnt_n != '0)
					wcnt_n = wcnt_n - iplk_pkg::WCNT_W'(1);
				wv_n[i] = 1'b0;
				wr_n[i] = '0;
				if (wcnt_n == '0)
					dstall_n = 1'b0;
			end
		end

		// memory and execute
		mem_n    = exec_q;
		exec_n   = exec_q;
		cnt_n    = cnt_q;
		xstall_n = xstall_q;
		ex_go    = 1'b0;
		if (!decode_q.valid) begin
			exec_n.valid = 1'b0;
		end else begin
			ex_go = 1'b1;
			if (cnt_q != '0) begin
				cnt_n = cnt_q - CD_W'(1);
				exec_n.valid = 1'b0;
				xstall_n = 1'b1;
				if (cnt_n != '0)
					ex_go = 1'b0;
			end
			if (ex_go) begin
				if (xstall_n) begin
					exec_n   = decode_q;
					xstall_n = 1'b0;
				end else begin
					cnt_n = CD_W'(lat_dec - iplk_pkg::LAT_W'(1));
					if (cnt_n != '0) begin
						xstall_n = 1'b1;
						exec_n.valid = 1'b0;
					end else begin
						exec_n = decode_q;
					end
				end
			end
		end

		// decode
		decode_n = decode_q;
		hit_a    = 1'b0;
		hit_b    = 1'b0;
		sb_wr.inc_en  = 1'b0;
		sb_wr.inc_reg = fetch_q.dest;
		if (!xstall_n) begin
			if (!fetch_q.valid || dstall_n) begin
				decode_n.valid = 1'b0;
			end else begin
				hit_a = (fetch_q.nsrc != '0) && sb_busy.busy_a;
				hit_b = fetch_q.nsrc[1] && sb_busy.busy_b;
				if (hit_a) begin
					wv_n[0] = 1'b1;
					wr_n[0] = fetch_q.src_a;
					if (wcnt_n != iplk_pkg::WCNT_W'(iplk_pkg::WCNT_SAT))
						wcnt_n = wcnt_n + iplk_pkg::WCNT_W'(1);
					dstall_n = 1'b1;
				end
				if (hit_b) begin
					wv_n[1] = 1'b1;
					wr_n[1] = fetch_q.src_b;
					if (wcnt_n != iplk_pkg::WCNT_W'(iplk_pkg::WCNT_SAT))
						wcnt_n = wcnt_n + iplk_pkg::WCNT_W'(1);
					dstall_n = 1'b1;
				end
				if (hit_a || hit_b) begin
					decode_n.valid = 1'b0;
				end else begin
					sb_wr.inc_en = commit & fetch_q.has_dest;
					if (fetch_q.branch)
						cstall_n = 1'b1;
					decode_n = fetch_q;
				end
			end
		end

		// fetch
		fetch_n = fetch_q;
		seq_n   = seq_q;
		accept  = 1'b0;
		if (!(xstall_n || dstall_n)) begin
			if (cstall_n) begin
				fetch_n.valid = 1'b0;
			end else begin
				fetch_n = '0;
				fetch_n.valid = 1'b1;
				if (item.trace_end) begin
					fetch_n.is_end = 1'b1;
				end else begin
					fetch_n.nsrc     = item.source_count;
					fetch_n.src_a    = item.source_a;
					fetch_n.src_b    = item.source_b;
					fetch_n.has_dest = item.dest_present;
					fetch_n.dest     = item.dest_reg;
					fetch_n.branch   = item.is_branch;
					fetch_n.op_class = item.op_class;
					fetch_n.seq      = seq_q;
					seq_n  = seq_q + iplk_pkg::SEQ_W'(1);
					accept = 1'b1;
				end
			end
		end

		// result of this tick; frozen once done
		res = '0;
		if (done_q) begin
			res.sim_done = 1'b1;
		end else begin
			res.fetch_accept  = accept;
			res.retire_valid  = retired;
			res.retire_seq    = retired ? mem_q.seq : '0;
			res.data_stall    = dstall_n;
			res.control_stall = cstall_n;
			res.exec_stall    = xstall_n;
			res.sim_done      = done_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_q  <= '0;
			decode_q <= '0;
			exec_q   <= '0;
			mem_q    <= '0;
			cnt_q    <= '0;
			dstall_q <= 1'b0;
			cstall_q <= 1'b0;
			xstall_q <= 1'b0;
			wv_q     <= '0;
			wr_q     <= '0;
			wcnt_q   <= '0;
			seq_q    <= '0;
			done_q   <= 1'b0;
		end else if (commit) begin
			fetch_q  <= fetch_n;
			decode_q <= decode_n;
			exec_q   <= exec_n;
			mem_q    <= mem_n;
			cnt_q    <= cnt_n;
			dstall_q <= dstall_n;
			cstall_q <= cstall_n;
			xstall_q <= xstall_n;
			wv_q     <= wv_n;
			wr_q     <= wr_n;
			wcnt_q   <= wcnt_n;
			seq_q    <= seq_n;
			done_q   <= done_n;
		end
	end

endmodule

// ===== rtl/iplk_checker.sv =====
// Port-level checks on the result stream of inorder_pipeline_interlock_core.
// Depends on iplk_pkg; bound to the top level at the end of this file.
module iplk_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       fetch_accept,
	input logic                       retire_valid,
	input logic [iplk_pkg::SEQ_W-1:0] retire_seq,
	input logic                       data_stall,
	input logic                       control_stall,
	input logic                       exec_stall,
	input logic                       sim_done
);

	logic                       done_seen_q;
	logic [iplk_pkg::SEQ_W-1:0] exp_seq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_seen_q <= 1'b0;
			exp_seq_q   <= '0;
		end else if (out_valid && out_ready) begin
			if (sim_done)
				done_seen_q <= 1'b1;
			if (retire_valid)
				exp_seq_q <= exp_seq_q + iplk_pkg::SEQ_W'(1);
		end
	end

	// stalled result holds its retire, fetch and done fields
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(retire_seq)
			&& $stable(retire_valid) && $stable(fetch_accept) && $stable(sim_done))
		else $error("result changed while stalled");

	// once done, every later result is frozen
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_seen_q |-> sim_done && !fetch_accept && !retire_valid
			&& !data_stall && !control_stall && !exec_stall)
		else $error("activity after done");

	// retirement is in fetch order with no gap
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && retire_valid |-> retire_seq == exp_seq_q)
		else $error("retire sequence out of order");

	// fetch takes an instruction only when no stall stands
	a_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fetch_accept |-> !exec_stall && !data_stall && !control_stall)
		else $error("fetch transfer under stall");

endmodule

bind inorder_pipeline_interlock_core iplk_checker u_iplk_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for inorder_pipeline_interlock_core: one input transfer is one pipeline tick.
// Depends on iplk_pkg and the core; an in-bench pipeline predictor checks every result transfer.
module testbench;
	import iplk_pkg::*;

	localparam int NUM_REGS      = REGISTER_COUNT_DEF;
	localparam int LATENCY_MAX   = LATENCY_MAX_DEF;
	localparam int KNOWN_CLASSES = 23;
	localparam int CLASS_LAT [KNOWN_CLASSES] = '{
		1, 1, 1, 1, 1, 1, 1, 1, 2, 4, 2, 1, 2, 1, 2, 2, 1, 4, 2, 4, 16, 2, 2
	};
	localparam int QUIET_LIMIT   = 5000;
	localparam int HOLD_OFF      = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int ITEM_W        = $bits(in_item_t);

	// Whole pipeline state as the predictor tracks it
	typedef struct packed {
		logic [NUM_REGS-1:0][BUSY_W-1:0]     busy;
		stage_t                              fe;
		stage_t                              de;
		stage_t                              ex;
		stage_t                              mem;
		logic [4:0]                          countdown;
		logic                                dstall;
		logic                                cstall;
		logic                                xstall;
		logic [WAIT_SLOTS-1:0]               wvalid;
		logic [WAIT_SLOTS-1:0][REG_W-1:0]    wreg;
		logic [WCNT_W-1:0]                   wcnt;
		logic [SEQ_W-1:0]                    seq;
		logic                                done;
	} pipe_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                trace_end = 1'b0;
	logic [NSRC_W-1:0]   source_count = '0;
	logic [REG_W-1:0]    source_a = '0;
	logic [REG_W-1:0]    source_b = '0;
	logic                dest_present = 1'b0;
	logic [REG_W-1:0]    dest_reg = '0;
	logic                is_branch = 1'b0;
	logic [CLS_W-1:0]    op_class = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                fetch_accept;
	logic                retire_valid;
	logic [SEQ_W-1:0]    retire_seq;
	logic                data_stall;
	logic                control_stall;
	logic                exec_stall;
	logic                sim_done;

	pipe_t   pipe = '0;
	result_t reports_due[$];
	int      errors = 0;
	int      tx_gap_pct = 0;
	int      rx_stall_pct = 0;
	int      hold_cycles = 0;

	inorder_pipeline_interlock_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.trace_end    (trace_end),
		.source_count (source_count),
		.source_a     (source_a),
		.source_b     (source_b),
		.dest_present (dest_present),
		.dest_reg     (dest_reg),
		.is_branch    (is_branch),
		.op_class     (op_class),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.fetch_accept (fetch_accept),
		.retire_valid (retire_valid),
		.retire_seq   (retire_seq),
		.data_stall   (data_stall),
		.control_stall(control_stall),
		.exec_stall   (exec_stall),
		.sim_done     (sim_done)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Execute latency of one op from the class table, clamped; end markers and unknown classes bypass the table
	function automatic int exec_cycles(input stage_t op);
		int lat;
		lat = 1;
		if (!op.is_end && int'(op.op_class) < KNOWN_CLASSES)
			lat = CLASS_LAT[op.op_class];
		if (lat < 1)
			lat = 1;
		if (lat > LATENCY_MAX)
			lat = LATENCY_MAX;
		return lat;
	endfunction

	// Advance the pipeline by one tick with the offered instruction and return the tick report.
	// Stages run writeback first, so each later stage sees what earlier ones held at tick start.
	function automatic result_t step_pipeline(inout pipe_t s, input in_item_t it);
		result_t          r;
		int               i;
		int               n;
		bit               hold;
		logic [REG_W-1:0] src;
		r = '0;
		// Once the end marker has retired the pipeline is frozen
		if (s.done) begin
			r.sim_done = 1'b1;
			return r;
		end

		// Writeback: release the destination and any wait slot parked on it
		if (s.mem.valid) begin
			if (s.mem.is_end) begin
				s.done = 1'b1;
			end else begin
				if (s.mem.branch)
					s.cstall = 1'b0;
				if (s.mem.has_dest) begin
					if (s.busy[s.mem.dest] != 0)
						s.busy[s.mem.dest] = s.busy[s.mem.dest] - BUSY_W'(1);
					for (i = 0; i < WAIT_SLOTS; i++) begin
						if (s.wvalid[i] && s.wreg[i] == s.mem.dest) begin
							if (s.wcnt != 0)
								s.wcnt = s.wcnt - WCNT_W'(1);
							s.wvalid[i] = 1'b0;
							s.wreg[i] = '0;
							if (s.wcnt == 0)
								s.dstall = 1'b0;
						end
					end
				end
				r.retire_valid = 1'b1;
				r.retire_seq = s.mem.seq;
			end
		end
		s.mem = s.ex;

		// Execute: count down a multi-cycle op, then hand it on
		if (!s.de.valid) begin
			s.ex.valid = 1'b0;
		end else begin
			hold = 1'b0;
			if (s.countdown != 0) begin
				s.countdown = s.countdown - 5'(1);
				s.ex.valid = 1'b0;
				s.xstall = 1'b1;
				if (s.countdown != 0)
					hold = 1'b1;
			end
			if (!hold) begin
				if (s.xstall) begin
					s.ex = s.de;
					s.xstall = 1'b0;
				end else begin
					s.countdown = 5'(exec_cycles(s.de) - 1);
					if (s.countdown != 0) begin
						s.xstall = 1'b1;
						s.ex.valid = 1'b0;
					end else begin
						s.ex = s.de;
					end
				end
			end
		end

		// Decode: check up to two sources against the busy counts
		if (!s.xstall) begin
			if (!s.fe.valid || s.dstall) begin
				s.de.valid = 1'b0;
			end else begin
				n = (s.fe.nsrc > 2) ? 2 : int'(s.fe.nsrc);
				for (i = 0; i < n; i++) begin
					src = (i == 0) ? s.fe.src_a : s.fe.src_b;
					if (s.busy[src] != 0) begin
						s.wvalid[i] = 1'b1;
						s.wreg[i] = src;
						if (s.wcnt < WCNT_SAT)
							s.wcnt = s.wcnt + WCNT_W'(1);
						s.dstall = 1'b1;
					end
				end
				if (s.dstall) begin
					s.de.valid = 1'b0;
				end else begin
					if (s.fe.has_dest && s.busy[s.fe.dest] < BUSY_SAT)
						s.busy[s.fe.dest] = s.busy[s.fe.dest] + BUSY_W'(1);
					if (s.fe.branch)
						s.cstall = 1'b1;
					s.de = s.fe;
				end
			end
		end

		// Fetch: hold on data or execute stalls, drop the latch behind a branch
		if (!(s.xstall || s.dstall)) begin
			if (s.cstall) begin
				s.fe.valid = 1'b0;
			end else begin
				s.fe = '0;
				s.fe.valid = 1'b1;
				if (it.trace_end) begin
					s.fe.is_end = 1'b1;
				end else begin
					s.fe.nsrc = it.source_count;
					s.fe.src_a = it.source_a;
					s.fe.src_b = it.source_b;
					s.fe.has_dest = it.dest_present;
					s.fe.dest = it.dest_reg;
					s.fe.branch = it.is_branch;
					s.fe.op_class = it.op_class;
					s.fe.seq = s.seq;
					s.seq = s.seq + SEQ_W'(1);
					r.fetch_accept = 1'b1;
				end
			end
		end

		r.data_stall = s.dstall;
		r.control_stall = s.cstall;
		r.exec_stall = s.xstall;
		r.sim_done = s.done;
		return r;
	endfunction

	function automatic in_item_t make_instr(input int nsrc, input int a, input int b,
			input bit has_dest, input int d, input bit branch, input int cls);
		in_item_t it;
		it = '0;
		it.source_count = NSRC_W'(nsrc);
		it.source_a = REG_W'(a);
		it.source_b = REG_W'(b);
		it.dest_present = has_dest;
		it.dest_reg = REG_W'(d);
		it.is_branch = branch;
		it.op_class = CLS_W'(cls);
		return it;
	endfunction

	// Favor a handful of registers so that dependencies are common
	function automatic logic [REG_W-1:0] pick_reg();
		return ($urandom_range(99) < 70) ? REG_W'($urandom_range(3)) : REG_W'($urandom_range(31));
	endfunction

	// True when a trace-end tick offered now would load an end marker into fetch
	function automatic bit end_marker_lands();
		pipe_t    probe;
		in_item_t it;
		result_t  unused;
		probe = pipe;
		it = '0;
		it.trace_end = 1'b1;
		unused = step_pipeline(probe, it);
		return probe.fe.valid && probe.fe.is_end;
	endfunction

	function automatic in_item_t random_instr();
		in_item_t it;
		int       pick;
		it = '0;
		it.source_count = NSRC_W'($urandom_range(3));
		it.source_a = pick_reg();
		it.source_b = pick_reg();
		it.dest_present = ($urandom_range(99) < 60);
		it.dest_reg = pick_reg();
		it.is_branch = ($urandom_range(99) < 10);
		pick = $urandom_range(99);
		if (pick < 60)
			it.op_class = CLS_W'($urandom_range(7));
		else if (pick < 90)
			it.op_class = CLS_W'($urandom_range(22, 8));
		else
			it.op_class = CLS_W'($urandom_range(31));
		// Trace end only where fetch would ignore it, so the run keeps going
		if ($urandom_range(99) < 4 && !end_marker_lands())
			it.trace_end = 1'b1;
		return it;
	endfunction

	// Offer one tick, hold it until the transfer, then log the predicted report.
	// Called at a rising edge; returns at the edge of the transfer with valid still high.
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		trace_end <= it.trace_end;
		source_count <= it.source_count;
		source_a <= it.source_a;
		source_b <= it.source_b;
		dest_present <= it.dest_present;
		dest_reg <= it.dest_reg;
		is_branch <= it.is_branch;
		op_class <= it.op_class;
		do
			@(posedge clk);
		while (!in_ready);
		reports_due.push_back(step_pipeline(pipe, it));
	endtask

	// Drop valid and wait until every predicted report has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string field, input logic [SEQ_W-1:0] want,
			input logic [SEQ_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			errors++;
		end
	endtask

	// Result side: check each transfer against the oldest prediction, then pick the next ready
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {fetch_accept, retire_valid, retire_seq, data_stall, control_stall,
				exec_stall, sim_done};
			if (reports_due.size() == 0) begin
				$display("%0t: unexpected result transfer, expected none, got %h", $time, got);
				errors++;
			end else begin
				want = reports_due.pop_front();
				check_field("fetch_accept", SEQ_W'(want.fetch_accept),
					SEQ_W'(got.fetch_accept));
				check_field("retire_valid", SEQ_W'(want.retire_valid),
					SEQ_W'(got.retire_valid));
				check_field("retire_seq", want.retire_seq, got.retire_seq);
				check_field("data_stall", SEQ_W'(want.data_stall), SEQ_W'(got.data_stall));
				check_field("control_stall", SEQ_W'(want.control_stall),
					SEQ_W'(got.control_stall));
				check_field("exec_stall", SEQ_W'(want.exec_stall), SEQ_W'(got.exec_stall));
				check_field("sim_done", SEQ_W'(want.sim_done), SEQ_W'(got.sim_done));
			end
		end
		// A requested hold-off wins over the random stall rate
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles--;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Watchdog: end the run after a long stretch without any transfer
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Extremes of every field, dependency stalls, long execute, branches, source count of three
	task automatic test_directed();
		in_item_t seq_list[$];
		seq_list = '{
			make_instr(0, 0, 0, 1, 0, 0, 0),
			make_instr(0, 31, 31, 1, 31, 0, 31),
			make_instr(2, 31, 0, 1, 5, 0, 1),
			make_instr(0, 0, 0, 0, 0, 0, 0),
			make_instr(0, 0, 0, 0, 0, 0, 0),
			make_instr(0, 0, 0, 1, 7, 0, 20),
			make_instr(2, 7, 7, 0, 0, 0, 0),
			make_instr(0, 0, 0, 0, 0, 0, 0),
			make_instr(0, 0, 0, 0, 0, 0, 0),
			make_instr(3, 1, 2, 1, 3, 0, 9),
			make_instr(0, 0, 0, 1, 4, 0, 17),
			make_instr(2, 3, 4, 1, 3, 0, 2),
			make_instr(0, 0, 0, 0, 0, 0, 0),
			make_instr(0, 0, 0, 0, 0, 1, 8),
			make_instr(1, 31, 0, 1, 31, 1, 31),
			make_instr(0, 0, 0, 0, 0, 0, 0),
			make_instr(0, 0, 0, 0, 0, 0, 0),
			make_instr(0, 0, 0, 0, 0, 0, 0),
			make_instr(3, 31, 31, 1, 31, 1, 31),
			make_instr(3, 31, 31, 0, 0, 0, 0),
			make_instr(0, 0, 0, 0, 0, 0, 0),
			make_instr(0, 0, 0, 0, 0, 0, 0)
		};
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		foreach (seq_list[k])
			send_item(seq_list[k]);
		drain();
	endtask

	task automatic test_random(input int count, input int gap_pct, input int stall_pct);
		tx_gap_pct = gap_pct;
		rx_stall_pct = stall_pct;
		repeat (count)
			send_item(random_instr());
		drain();
	endtask

	// Starve the result side so the core fills and drops in_ready, then let it all drain
	task automatic test_backpressure();
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		hold_cycles = HOLD_OFF;
		repeat (80)
			send_item(random_instr());
		drain();
	endtask

	// Land an end marker, then keep ticking: after retirement every report is sim_done alone
	task automatic test_trace_end();
		in_item_t it;
		tx_gap_pct = 23;
		rx_stall_pct = 23;
		it = make_instr(0, 0, 0, 0, 0, 0, 0);
		it.trace_end = 1'b1;
		do
			send_item(it);
		while (!(pipe.fe.valid && pipe.fe.is_end));
		repeat (40) begin
			it = in_item_t'(ITEM_W'($urandom()));
			send_item(it);
		end
		drain();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(450, 0, 0);
		test_random(450, 75, 0);
		test_random(450, 0, 75);
		test_random(450, 23, 23);
		test_backpressure();
		test_trace_end();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && reports_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
